[hw/rtl/rwlt_pkg.sv]
// ----------------------------------------------------------------------------
// rwlt_pkg
// Shared types and constants for the reader/writer lock table.
// ----------------------------------------------------------------------------
package rwlt_pkg;

   localparam int LOCK_ID_W = 64;
   localparam int COUNT_W   = 8;
   localparam int ENTRY_W   = LOCK_ID_W + COUNT_W;

   localparam logic [COUNT_W-1:0] WRITE_MARK = 8'hFF;
   localparam logic [COUNT_W-1:0] READER_MAX = 8'd254;

   typedef enum logic [1:0] {
      OP_ACQ_READ  = 2'd0,
      OP_ACQ_WRITE = 2'd1,
      OP_REL_READ  = 2'd2,
      OP_REL_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE   = 2'd0,
      STATUS_HELD   = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_ABSENT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DRAIN,
      FSM_EXEC
   } fsm_type;

endpackage

[hw/rtl/rwlt_entry_ram.sv]
// ----------------------------------------------------------------------------
// rwlt_entry_ram
// Single write port, single read port RAM holding {lock id, count} entries.
// ----------------------------------------------------------------------------
module rwlt_entry_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 72
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/reader_writer_lock_table.sv]
// ----------------------------------------------------------------------------
// reader_writer_lock_table
// Reader/writer lock table keyed by a 64-bit lock id.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one beat per request, tdata = {lock_id, op}. Each request yields
//           exactly one rsp_* beat, tdata = {holder_count, status, granted}.
//   The id/count pairs live in a RAM of TABLE_ENTRIES words; valid bits are
//   flops. A request walks every RAM word (one read per cycle) to find the
//   lowest matching entry and the lowest free one, then updates the table.
//   A new request is accepted only in the idle state, after the previous one
//   has updated the table; the walk uses the single RAM read port.
//   Reset (synchronous, active high) clears every valid bit, i.e. empties the
//   table; no clearing pass is needed. RAM contents are don't care.
//   A finished response sits in the output register while the next request
//   is accepted and walked; if rsp_tready stays low the block stalls before
//   updating the table for that next request, so no beat is ever dropped.
//   Only one request is in flight, so the walk never overlaps a RAM write.
// ----------------------------------------------------------------------------
module reader_writer_lock_table
   import rwlt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [1:0] op, [65:2] lock_id, [71:66] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] granted, [2:1] status,
                                    // [10:3] holder_count, [15:11] zero
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   // state machine
   fsm_type state_ff, state_in;

   // captured request
   op_type               op_ff;
   logic [LOCK_ID_W-1:0] key_ff;

   // walk
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [ENTRY_W-1:0] rd_data;

   // walk results
   logic               hit_ff, free_ff;
   logic [IDX_W-1:0]   hit_idx_ff, free_idx_ff;
   logic [COUNT_W-1:0] hit_count_ff;

   logic [TABLE_ENTRIES-1:0] valid_ff;

   // output register
   logic         rsp_vld_ff, rsp_vld_in;
   logic [10:0]  rsp_data_ff;

   // update controls
   logic               mem_we;
   logic [IDX_W-1:0]   wr_idx;
   logic [COUNT_W-1:0] wr_count;
   logic               valid_set, valid_clr;
   logic               res_load;
   logic               res_granted;
   status_type         res_status;
   logic [COUNT_W-1:0] res_count;

   logic req_beat;
   logic entry_vld, entry_match;

   assign req_tready = (state_ff == FSM_IDLE);
   assign req_beat   = req_tvalid && req_tready;

   rwlt_entry_ram #(
      .DEPTH (TABLE_ENTRIES),
      .WIDTH (ENTRY_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_idx),
      .wr_data ({key_ff, wr_count}),
      .rd_addr (scan_idx_ff),
      .rd_data (rd_data)
   );

   assign entry_vld   = valid_ff[rd_idx_ff];
   assign entry_match = entry_vld && (rd_data[COUNT_W +: LOCK_ID_W] == key_ff);

   // next state, table update and response
   always_comb begin
      state_in    = state_ff;
      scan_idx_in = scan_idx_ff;
      mem_we      = 1'b0;
      wr_idx      = hit_idx_ff;
      wr_count    = hit_count_ff;
      valid_set   = 1'b0;
      valid_clr   = 1'b0;
      res_load    = 1'b0;
      res_granted = 1'b0;
      res_status  = STATUS_DONE;
      res_count   = '0;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;

      case (state_ff)
         FSM_IDLE: begin
            scan_idx_in = '0;
            if (req_beat) begin
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            if (scan_idx_ff == LAST_IDX) begin
               state_in = FSM_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
         end
         FSM_DRAIN: begin
            state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            // wait for room in the output register
            if (!rsp_vld_ff || rsp_tready) begin
               res_load   = 1'b1;
               rsp_vld_in = 1'b1;
               state_in   = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      if (res_load) begin
         case (op_ff)
            OP_ACQ_READ, OP_ACQ_WRITE: begin
               if (hit_ff) begin
                  res_count = hit_count_ff;
                  if (op_ff == OP_ACQ_READ && hit_count_ff < READER_MAX) begin
                     res_count   = hit_count_ff + 1'b1;
                     wr_count    = res_count;
                     mem_we      = 1'b1;
                     res_granted = 1'b1;
                  end else begin
                     res_status = STATUS_HELD;
                  end
               end else if (!free_ff) begin
                  res_status = STATUS_FULL;
               end else begin
                  res_count   = (op_ff == OP_ACQ_READ) ? COUNT_W'(1) : WRITE_MARK;
                  wr_idx      = free_idx_ff;
                  wr_count    = res_count;
                  mem_we      = 1'b1;
                  valid_set   = 1'b1;
                  res_granted = 1'b1;
               end
            end
            OP_REL_READ: begin
               if (!hit_ff) begin
                  res_status = STATUS_ABSENT;
               end else if (hit_count_ff == WRITE_MARK) begin
                  res_status = STATUS_HELD;
                  res_count  = WRITE_MARK;
               end else begin
                  res_count   = (hit_count_ff == '0) ? '0 : hit_count_ff - 1'b1;
                  wr_count    = res_count;
                  mem_we      = 1'b1;
                  valid_clr   = (res_count == '0);
                  res_granted = 1'b1;
               end
            end
            OP_REL_WRITE: begin
               if (!hit_ff) begin
                  res_status = STATUS_ABSENT;
               end else begin
                  valid_clr   = 1'b1;
                  res_granted = 1'b1;
               end
            end
            default: begin
               res_status = STATUS_ABSENT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FSM_IDLE;
         scan_idx_ff <= '0;
         rd_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         valid_ff    <= '0;
         hit_ff      <= 1'b0;
         free_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_idx_ff <= scan_idx_in;
         rd_vld_ff   <= (state_ff == FSM_SCAN);
         rsp_vld_ff  <= rsp_vld_in;
         if (valid_set) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (valid_clr) begin
            valid_ff[wr_idx] <= 1'b0;
         end
         // lowest match and lowest free slot, in walk order
         if (req_beat) begin
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else if (rd_vld_ff) begin
            if (entry_match && !hit_ff) begin
               hit_ff <= 1'b1;
            end
            if (!entry_vld && !free_ff) begin
               free_ff <= 1'b1;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_idx_ff;
      if (req_beat) begin
         op_ff  <= op_type'(req_tdata[1:0]);
         key_ff <= req_tdata[2 +: LOCK_ID_W];
      end
      if (rd_vld_ff && entry_match && !hit_ff) begin
         hit_idx_ff   <= rd_idx_ff;
         hit_count_ff <= rd_data[COUNT_W-1:0];
      end
      if (rd_vld_ff && !entry_vld && !free_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
      if (res_load) begin
         rsp_data_ff <= {res_count, res_status, res_granted};
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

endmodule
